### rtl/ccp_pkg.sv
// Shared constants, types and the centre rounding function for the circumcircle block.
// No dependencies.
package ccp_pkg;

  // Result widths fixed by the output format
  localparam int CENTRE_W = 16;
  localparam int RADIUS_W = 20;
  // Quotient bits kept for the centre; anything larger saturates anyway
  localparam int CQ_W     = 17;

  localparam logic [CQ_W:0] POS_LIMIT = (CQ_W+1)'(32767);
  localparam logic [CQ_W:0] NEG_LIMIT = (CQ_W+1)'(32768);
  localparam logic signed [CENTRE_W-1:0] CENTRE_MAX = 16'sh7fff;
  localparam logic signed [CENTRE_W-1:0] CENTRE_MIN = 16'sh8000;

  typedef struct packed {
    logic signed [CENTRE_W-1:0] val;
    logic                       clip;
  } centre_t;

  // Magnitude quotient plus round bit, sign applied, saturated to 16 bits
  function automatic centre_t centre_round(logic [CQ_W-1:0] q, logic up, logic neg,
                                           logic ovf);
    logic [CQ_W:0] qr;
    logic [CQ_W:0] nqr;
    centre_t       res;
    qr       = {1'b0, q} + (CQ_W+1)'(up);
    nqr      = -qr;
    res.clip = 1'b0;
    if (neg) begin
      if (ovf || (qr > NEG_LIMIT)) begin
        res.val  = CENTRE_MIN;
        res.clip = 1'b1;
      end else begin
        res.val = nqr[CENTRE_W-1:0];
      end
    end else begin
      if (ovf || (qr > POS_LIMIT)) begin
        res.val  = CENTRE_MAX;
        res.clip = 1'b1;
      end else begin
        res.val = qr[CENTRE_W-1:0];
      end
    end
    return res;
  endfunction

endpackage

### rtl/ccp_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Self-contained; carries a sideband word alongside each beat.
module ccp_div #(
  parameter int DW  = 40,
  parameter int VW  = 26,
  parameter int QB  = 17,
  parameter int SBW = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [DW-1:0]  dividend_i,
  input  logic [VW-1:0]  divisor_i,
  input  logic [SBW-1:0] sb_i,
  output logic           valid_o,
  output logic [QB-1:0]  quot_o,
  output logic [VW-1:0]  rem_o,
  output logic           ovf_o,
  output logic [SBW-1:0] sb_o
);

  localparam int HW = DW - QB;
  localparam int CW = (HW > VW) ? HW : VW;

  logic           vld_q [QB+1];
  logic [VW-1:0]  rem_q [QB+1];
  logic [QB-1:0]  quo_q [QB+1];
  logic [QB-1:0]  low_q [QB+1];
  logic [VW-1:0]  dvs_q [QB+1];
  logic           ovf_q [QB+1];
  logic [SBW-1:0] sb_q  [QB+1];

  // Entry: top part of the dividend must be below the divisor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q[0] <= 1'b0;
    else         vld_q[0] <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= VW'(dividend_i[DW-1:QB]);
    low_q[0] <= dividend_i[QB-1:0];
    quo_q[0] <= '0;
    dvs_q[0] <= divisor_i;
    ovf_q[0] <= CW'(dividend_i[DW-1:QB]) >= CW'(divisor_i);
    sb_q[0]  <= sb_i;
  end

  // One trial subtraction per stage
  for (genvar g = 0; g < QB; g++) begin : g_stage
    logic [VW:0] cand;
    logic [VW:0] diff;
    logic        ge;
    assign cand = {rem_q[g], low_q[g][QB-1]};
    assign diff = cand - {1'b0, dvs_q[g]};
    assign ge   = cand >= {1'b0, dvs_q[g]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[g+1] <= 1'b0;
      else         vld_q[g+1] <= vld_q[g];
    end

    always_ff @(posedge clk_i) begin
      rem_q[g+1] <= ge ? diff[VW-1:0] : cand[VW-1:0];
      quo_q[g+1] <= {quo_q[g][QB-2:0], ge};
      low_q[g+1] <= {low_q[g][QB-2:0], 1'b0};
      dvs_q[g+1] <= dvs_q[g];
      ovf_q[g+1] <= ovf_q[g];
      sb_q[g+1]  <= sb_q[g];
    end
  end

  assign valid_o = vld_q[QB];
  assign quot_o  = quo_q[QB];
  assign rem_o   = rem_q[QB];
  assign ovf_o   = ovf_q[QB];
  assign sb_o    = sb_q[QB];

endmodule

### rtl/ccp_sqrt.sv
// Radius magnitude: split squares of the offsets, their scaled sum, then a
// pipelined restoring integer square root, one root bit per stage. Self-contained.
module ccp_sqrt #(
  parameter int MW  = 40,
  parameter int F   = 4,
  parameter int SBW = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [MW-1:0]       ux_i,
  input  logic [MW-1:0]       uy_i,
  input  logic [SBW-1:0]      sb_i,
  output logic                valid_o,
  output logic [MW+F:0]       root_o,
  output logic [SBW-1:0]      sb_o
);

  localparam int H  = (MW + 1) / 2;
  localparam int LW = MW - H;
  localparam int SW = MW + 1 + F;
  localparam int TW = 2 * SW;

  // Stage A: partial products of each half
  logic              va_q;
  logic [2*LW-1:0]   xhh_q, yhh_q;
  logic [LW+H-1:0]   xhl_q, yhl_q;
  logic [2*H-1:0]    xll_q, yll_q;
  logic [SBW-1:0]    sba_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else         va_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    xhh_q <= ux_i[MW-1:H] * ux_i[MW-1:H];
    xhl_q <= ux_i[MW-1:H] * ux_i[H-1:0];
    xll_q <= ux_i[H-1:0] * ux_i[H-1:0];
    yhh_q <= uy_i[MW-1:H] * uy_i[MW-1:H];
    yhl_q <= uy_i[MW-1:H] * uy_i[H-1:0];
    yll_q <= uy_i[H-1:0] * uy_i[H-1:0];
    sba_q <= sb_i;
  end

  // Stage B: recombine squares
  logic            vb_q;
  logic [2*MW-1:0] sqx_q, sqy_q;
  logic [SBW-1:0]  sbb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else         vb_q <= va_q;
  end

  always_ff @(posedge clk_i) begin
    sqx_q <= ((2*MW)'(xhh_q) << (2*H)) + ((2*MW)'(xhl_q) << (H+1)) + (2*MW)'(xll_q);
    sqy_q <= ((2*MW)'(yhh_q) << (2*H)) + ((2*MW)'(yhl_q) << (H+1)) + (2*MW)'(yll_q);
    sbb_q <= sba_q;
  end

  // Root pipeline arrays; index 0 is the scaled radicand
  logic           vld_q  [SW+1];
  logic [TW-1:0]  rad_q  [SW+1];
  logic [SW:0]    rem_q  [SW+1];
  logic [SW-1:0]  root_q [SW+1];
  logic [SBW-1:0] sb_q   [SW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q[0] <= 1'b0;
    else         vld_q[0] <= vb_q;
  end

  always_ff @(posedge clk_i) begin
    rad_q[0]  <= (TW'(sqx_q) + TW'(sqy_q)) << (2*F);
    rem_q[0]  <= '0;
    root_q[0] <= '0;
    sb_q[0]   <= sbb_q;
  end

  for (genvar g = 0; g < SW; g++) begin : g_root
    logic [SW+2:0] cand;
    logic [SW+2:0] trial;
    logic [SW+2:0] diff;
    logic          ge;
    assign cand  = {rem_q[g], rad_q[g][TW-1:TW-2]};
    assign trial = {1'b0, root_q[g], 2'b01};
    assign diff  = cand - trial;
    assign ge    = cand >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[g+1] <= 1'b0;
      else         vld_q[g+1] <= vld_q[g];
    end

    always_ff @(posedge clk_i) begin
      rem_q[g+1]  <= ge ? diff[SW:0] : cand[SW:0];
      root_q[g+1] <= {root_q[g][SW-2:0], ge};
      rad_q[g+1]  <= {rad_q[g][TW-3:0], 2'b00};
      sb_q[g+1]   <= sb_q[g];
    end
  end

  assign valid_o = vld_q[SW];
  assign root_o  = root_q[SW];
  assign sb_o    = sb_q[SW];

endmodule

### rtl/ccp_front.sv
// Front end: differences, determinant, centre numerators, sign fold and
// offsets of the second point from the centre. Six register stages, no package use.
module ccp_front #(
  parameter int CB = 12
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [CB-1:0]   x1_i,
  input  logic [CB-1:0]   y1_i,
  input  logic [CB-1:0]   x2_i,
  input  logic [CB-1:0]   y2_i,
  input  logic [CB-1:0]   x3_i,
  input  logic [CB-1:0]   y3_i,
  output logic            valid_o,
  output logic [3*CB+3:0] nmag_x_o,
  output logic [3*CB+3:0] nmag_y_o,
  output logic            nneg_x_o,
  output logic            nneg_y_o,
  output logic [2*CB+1:0] d_o,
  output logic [3*CB+3:0] ux_o,
  output logic [3*CB+3:0] uy_o,
  output logic            coll_o
);

  localparam int DTW = 2*CB + 3;   // determinant
  localparam int BW  = 2*CB + 2;   // b2, c2
  localparam int NW  = 3*CB + 4;   // numerators
  localparam int DUW = 2*CB + 2;   // 2|det|
  localparam int PW  = 3*CB + 2;   // x2*d
  localparam int EW  = 3*CB + 5;   // centre offset, signed
  localparam int MW  = 3*CB + 4;

  logic [5:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else         vld_q <= {vld_q[4:0], valid_i};
  end

  // Stage 1: differences and squares
  logic signed [CB:0] dx12_1_q, dy12_1_q, dx23_1_q, dy23_1_q;
  logic [2*CB-1:0]    xs1_q, ys1_q, xs2_q, ys2_q, xs3_q, ys3_q;
  logic [CB-1:0]      x2_1_q, y2_1_q;

  always_ff @(posedge clk_i) begin
    dx12_1_q <= $signed({1'b0, x1_i}) - $signed({1'b0, x2_i});
    dy12_1_q <= $signed({1'b0, y1_i}) - $signed({1'b0, y2_i});
    dx23_1_q <= $signed({1'b0, x2_i}) - $signed({1'b0, x3_i});
    dy23_1_q <= $signed({1'b0, y2_i}) - $signed({1'b0, y3_i});
    xs1_q    <= x1_i * x1_i;
    ys1_q    <= y1_i * y1_i;
    xs2_q    <= x2_i * x2_i;
    ys2_q    <= y2_i * y2_i;
    xs3_q    <= x3_i * x3_i;
    ys3_q    <= y3_i * y3_i;
    x2_1_q   <= x2_i;
    y2_1_q   <= y2_i;
  end

  // Stage 2: determinant and the power differences
  logic signed [DTW-1:0] det_2_q;
  logic signed [BW-1:0]  b2_q, c2_q;
  logic signed [CB:0]    dx12_2_q, dy12_2_q, dx23_2_q, dy23_2_q;
  logic [CB-1:0]         x2_2_q, y2_2_q;

  always_ff @(posedge clk_i) begin
    det_2_q  <= dx12_1_q * dy23_1_q - dx23_1_q * dy12_1_q;
    b2_q     <= $signed(BW'(xs1_q) + BW'(ys1_q)) - $signed(BW'(xs2_q) + BW'(ys2_q));
    c2_q     <= $signed(BW'(xs2_q) + BW'(ys2_q)) - $signed(BW'(xs3_q) + BW'(ys3_q));
    dx12_2_q <= dx12_1_q;
    dy12_2_q <= dy12_1_q;
    dx23_2_q <= dx23_1_q;
    dy23_2_q <= dy23_1_q;
    x2_2_q   <= x2_1_q;
    y2_2_q   <= y2_1_q;
  end

  // Stage 3: centre numerators
  logic signed [NW-1:0]  nx_3_q, ny_3_q;
  logic signed [DTW-1:0] det_3_q;
  logic [CB-1:0]         x2_3_q, y2_3_q;

  always_ff @(posedge clk_i) begin
    nx_3_q  <= b2_q * dy23_2_q - c2_q * dy12_2_q;
    ny_3_q  <= c2_q * dx12_2_q - b2_q * dx23_2_q;
    det_3_q <= det_2_q;
    x2_3_q  <= x2_2_q;
    y2_3_q  <= y2_2_q;
  end

  // Stage 4: fold the determinant sign into the numerators
  logic                  neg4;
  logic signed [DTW-1:0] absdet4;
  logic [DUW-1:0]        d_4_q;
  logic signed [NW-1:0]  nx_4_q, ny_4_q;
  logic                  coll_4_q;
  logic [CB-1:0]         x2_4_q, y2_4_q;

  assign neg4    = det_3_q[DTW-1];
  assign absdet4 = neg4 ? -det_3_q : det_3_q;

  always_ff @(posedge clk_i) begin
    d_4_q    <= {absdet4[DUW-2:0], 1'b0};
    nx_4_q   <= neg4 ? -nx_3_q : nx_3_q;
    ny_4_q   <= neg4 ? -ny_3_q : ny_3_q;
    coll_4_q <= (det_3_q == '0);
    x2_4_q   <= x2_3_q;
    y2_4_q   <= y2_3_q;
  end

  // Stage 5: scaled second point, numerator sign and magnitude
  logic [PW-1:0]        px_q, py_q;
  logic signed [NW-1:0] nx_5_q, ny_5_q;
  logic [NW-1:0]        nmx_5_q, nmy_5_q;
  logic [DUW-1:0]       d_5_q;
  logic                 coll_5_q;

  always_ff @(posedge clk_i) begin
    px_q     <= x2_4_q * d_4_q;
    py_q     <= y2_4_q * d_4_q;
    nx_5_q   <= nx_4_q;
    ny_5_q   <= ny_4_q;
    nmx_5_q  <= nx_4_q[NW-1] ? NW'(-nx_4_q) : NW'(nx_4_q);
    nmy_5_q  <= ny_4_q[NW-1] ? NW'(-ny_4_q) : NW'(ny_4_q);
    d_5_q    <= d_4_q;
    coll_5_q <= coll_4_q;
  end

  // Stage 6: offset of the second point from the exact centre, times d
  logic signed [EW-1:0] ex6, ey6;
  logic [MW-1:0]        ux_q, uy_q;
  logic [NW-1:0]        nmx_6_q, nmy_6_q;
  logic                 nsx_6_q, nsy_6_q;
  logic [DUW-1:0]       d_6_q;
  logic                 coll_6_q;

  assign ex6 = $signed({3'b000, px_q}) - $signed({nx_5_q[NW-1], nx_5_q});
  assign ey6 = $signed({3'b000, py_q}) - $signed({ny_5_q[NW-1], ny_5_q});

  always_ff @(posedge clk_i) begin
    ux_q     <= ex6[EW-1] ? MW'(-ex6) : MW'(ex6);
    uy_q     <= ey6[EW-1] ? MW'(-ey6) : MW'(ey6);
    nmx_6_q  <= nmx_5_q;
    nmy_6_q  <= nmy_5_q;
    nsx_6_q  <= nx_5_q[NW-1];
    nsy_6_q  <= ny_5_q[NW-1];
    d_6_q    <= d_5_q;
    coll_6_q <= coll_5_q;
  end

  assign valid_o  = vld_q[5];
  assign nmag_x_o = nmx_6_q;
  assign nmag_y_o = nmy_6_q;
  assign nneg_x_o = nsx_6_q;
  assign nneg_y_o = nsy_6_q;
  assign d_o      = d_6_q;
  assign ux_o     = ux_q;
  assign uy_o     = uy_q;
  assign coll_o   = coll_6_q;

endmodule

### rtl/circumcircle_three_points.sv
// Top level of the circumcircle block: front end, centre dividers, rounding,
// square root and radius divider in one pipeline. Uses ccp_pkg and all ccp_* modules.
//
//  channel   | signals                                         | direction
//  ----------+-------------------------------------------------+----------
//  points    | start_i, busy_o, first/second/third_x/y_i       | in
//  circle    | valid_o, center_x/y_o, radius_q4_o, collinear_o, | out
//            | clipped_o                                       |
//
// One beat enters per cycle; busy_o is held low. A beat passes the front end, the centre
// dividers, the rounding register, the square root (SW = 3*COORD_BITS+5+RADIUS_FRAC_BITS root bits),
// the radius divider and the output register, in that order.
// Reset clears only the valid bits. The receiver cannot stall, so nothing holds.
module circumcircle_three_points
  import ccp_pkg::*;
#(
  parameter int COORD_BITS       = 12,
  parameter int RADIUS_FRAC_BITS = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [COORD_BITS-1:0]      first_x_i,
  input  logic [COORD_BITS-1:0]      first_y_i,
  input  logic [COORD_BITS-1:0]      second_x_i,
  input  logic [COORD_BITS-1:0]      second_y_i,
  input  logic [COORD_BITS-1:0]      third_x_i,
  input  logic [COORD_BITS-1:0]      third_y_i,
  output logic                       valid_o,
  output logic signed [CENTRE_W-1:0] center_x_o,
  output logic signed [CENTRE_W-1:0] center_y_o,
  output logic [RADIUS_W-1:0]        radius_q4_o,
  output logic                       collinear_o,
  output logic                       clipped_o
);

  localparam int CB   = COORD_BITS;
  localparam int NW   = 3*CB + 4;
  localparam int DUW  = 2*CB + 2;
  localparam int MW   = 3*CB + 4;
  localparam int SW   = MW + 1 + RADIUS_FRAC_BITS;
  localparam int SBX  = 2*MW + DUW + 2;
  localparam int SBS  = 2*CENTRE_W + 2 + DUW;
  localparam int SBR  = 2*CENTRE_W + 2;

  assign busy_o = 1'b0;

  // Front end
  logic           fv;
  logic [NW-1:0]  nmx, nmy;
  logic           nsx, nsy;
  logic [DUW-1:0] fd;
  logic [MW-1:0]  fux, fuy;
  logic           fcoll;

  ccp_front #(.CB(CB)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (start_i),
    .x1_i     (first_x_i),
    .y1_i     (first_y_i),
    .x2_i     (second_x_i),
    .y2_i     (second_y_i),
    .x3_i     (third_x_i),
    .y3_i     (third_y_i),
    .valid_o  (fv),
    .nmag_x_o (nmx),
    .nmag_y_o (nmy),
    .nneg_x_o (nsx),
    .nneg_y_o (nsy),
    .d_o      (fd),
    .ux_o     (fux),
    .uy_o     (fuy),
    .coll_o   (fcoll)
  );

  // Centre dividers, x carries the rest of the beat
  logic            cvx, cvy;
  logic [CQ_W-1:0] qx, qy;
  logic [DUW-1:0]  rx, ry;
  logic            ovx, ovy;
  logic [SBX-1:0]  sbx_out;
  logic            sby_out;

  ccp_div #(.DW(NW), .VW(DUW), .QB(CQ_W), .SBW(SBX)) u_divx (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (fv),
    .dividend_i (nmx),
    .divisor_i  (fd),
    .sb_i       ({fux, fuy, fd, fcoll, nsx}),
    .valid_o    (cvx),
    .quot_o     (qx),
    .rem_o      (rx),
    .ovf_o      (ovx),
    .sb_o       (sbx_out)
  );

  ccp_div #(.DW(NW), .VW(DUW), .QB(CQ_W), .SBW(1)) u_divy (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (fv),
    .dividend_i (nmy),
    .divisor_i  (fd),
    .sb_i       (nsy),
    .valid_o    (cvy),
    .quot_o     (qy),
    .rem_o      (ry),
    .ovf_o      (ovy),
    .sb_o       (sby_out)
  );

  // Round half to even and saturate the centre
  logic [MW-1:0]  cux, cuy;
  logic [DUW-1:0] cd;
  logic           ccoll, csx;
  logic [DUW:0]   r2x, r2y;
  logic           upx, upy;
  centre_t        rcx, rcy;

  assign {cux, cuy, cd, ccoll, csx} = sbx_out;
  assign r2x = {rx, 1'b0};
  assign r2y = {ry, 1'b0};
  assign upx = (r2x > {1'b0, cd}) || ((r2x == {1'b0, cd}) && qx[0]);
  assign upy = (r2y > {1'b0, cd}) || ((r2y == {1'b0, cd}) && qy[0]);
  assign rcx = centre_round(qx, upx, csx, ovx);
  assign rcy = centre_round(qy, upy, sby_out, ovy);

  logic                       rv_q;
  logic signed [CENTRE_W-1:0] cx_q, cy_q;
  logic                       cclip_q, coll_q;
  logic [DUW-1:0]             d_q;
  logic [MW-1:0]              ux_q, uy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rv_q <= 1'b0;
    else         rv_q <= cvx & cvy;
  end

  always_ff @(posedge clk_i) begin
    cx_q    <= rcx.val;
    cy_q    <= rcy.val;
    cclip_q <= rcx.clip | rcy.clip;
    coll_q  <= ccoll;
    d_q     <= cd;
    ux_q    <= cux;
    uy_q    <= cuy;
  end

  // Square root of the scaled squared offset
  logic           sv;
  logic [SW-1:0]  root;
  logic [SBS-1:0] sbs_out;

  ccp_sqrt #(.MW(MW), .F(RADIUS_FRAC_BITS), .SBW(SBS)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rv_q),
    .ux_i    (ux_q),
    .uy_i    (uy_q),
    .sb_i    ({cx_q, cy_q, cclip_q, coll_q, d_q}),
    .valid_o (sv),
    .root_o  (root),
    .sb_o    (sbs_out)
  );

  // Radius: root over d, overflow means saturation
  logic [DUW-1:0]      sd;
  logic [SBR-1:0]      sb_pass;
  logic                kv;
  logic [RADIUS_W-1:0] kq;
  logic                kovf;
  logic [SBR-1:0]      sbr_out;

  assign {sb_pass, sd} = sbs_out;

  ccp_div #(.DW(SW), .VW(DUW), .QB(RADIUS_W), .SBW(SBR)) u_divr (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (sv),
    .dividend_i (root),
    .divisor_i  (sd),
    .sb_i       (sb_pass),
    .valid_o    (kv),
    .quot_o     (kq),
    .rem_o      (),
    .ovf_o      (kovf),
    .sb_o       (sbr_out)
  );

  // Output register
  logic signed [CENTRE_W-1:0] ocx, ocy;
  logic                       oclip, ocoll;
  logic                       ov_q;
  logic signed [CENTRE_W-1:0] ocx_q, ocy_q;
  logic [RADIUS_W-1:0]        ork_q;
  logic                       ocoll_q, oclip_q;

  assign {ocx, ocy, oclip, ocoll} = sbr_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else         ov_q <= kv;
  end

  always_ff @(posedge clk_i) begin
    if (ocoll) begin
      ocx_q   <= '0;
      ocy_q   <= '0;
      ork_q   <= '0;
      ocoll_q <= 1'b1;
      oclip_q <= 1'b0;
    end else begin
      ocx_q   <= ocx;
      ocy_q   <= ocy;
      ork_q   <= kovf ? '1 : kq;
      ocoll_q <= 1'b0;
      oclip_q <= oclip | kovf;
    end
  end

  assign valid_o     = ov_q;
  assign center_x_o  = ocx_q;
  assign center_y_o  = ocy_q;
  assign radius_q4_o = ork_q;
  assign collinear_o = ocoll_q;
  assign clipped_o   = oclip_q;

endmodule
